// ===== rtl/core/mbet_pkg.sv =====
// mbet_pkg: types, constants and helpers shared by the escape-time engine
// used by mbet_ctrl, mbet_dp and mandelbrot_escape_time; no dependencies
package mbet_pkg;

  localparam int unsigned FRAC_BITS = 26;

  // configuration register indexes
  localparam logic [2:0] CFG_RE_START  = 3'd0;
  localparam logic [2:0] CFG_IM_START  = 3'd1;
  localparam logic [2:0] CFG_STEP      = 3'd2;
  localparam logic [2:0] CFG_ITER_LIM  = 3'd3;
  localparam logic [2:0] CFG_ESCAPE_SQ = 3'd4;

  localparam logic signed [31:0] RE_START_RST  = -32'sd117440512;
  localparam logic signed [31:0] IM_START_RST  = -32'sd83886080;
  localparam logic [30:0]        STEP_RST      = 31'd163840;
  localparam logic [7:0]         ITER_LIM_RST  = 8'd255;
  localparam logic [30:0]        ESCAPE_SQ_RST = 31'd419430400;

  localparam logic [7:0] NEVER_ESCAPED = 8'd255;

  typedef enum logic [2:0] {
    MUL_PX_STEP,
    MUL_PY_STEP,
    MUL_RE_RE,
    MUL_IM_IM,
    MUL_RE_IM
  } mul_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CRE,
    S_CIM,
    S_CFIN,
    S_RR,
    S_II,
    S_CHK,
    S_UPD,
    S_OUT
  } state_e;

  typedef struct packed {
    logic     load_pix;
    mul_sel_e mul_sel;
    logic     set_cre;
    logic     set_cim;
    logic     save_rr;
    logic     save_diff;
    logic     upd_z;
    logic     gray_esc;
    logic     gray_max;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic escaped;
    logic iter_done;
    logic iter_zero;
  } dp_stat_t;

  // clamp a 64-bit signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/mbet_dp.sv =====
// mbet_dp: datapath with the shared 32x32 multiplier, z/c registers,
// iteration counter, configuration registers and result payload; uses mbet_pkg
module mbet_dp import mbet_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic [9:0]  pix_x_i,
  input  logic [9:0]  pix_y_i,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  output logic [9:0]  out_x_o,
  output logic [9:0]  out_y_o,
  output logic [7:0]  gray_o
);

  logic signed [31:0] re_start_q, im_start_q;
  logic [30:0]        step_q, escape_sq_q;
  logic [7:0]         iter_lim_q;

  logic [9:0]         px_q, py_q;
  logic signed [31:0] cre_q, cim_q, zre_q, zim_q;
  logic signed [63:0] p_q, rr_q, diff_q;
  logic [7:0]         iter_q, gray_q;
  logic [9:0]         out_x_q, out_y_q;
  logic [7:0]         out_gray_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] p_d;
  logic signed [31:0] cre_d, cim_d, zre_upd, zim_upd;
  logic [64:0]        mag2, limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      re_start_q  <= RE_START_RST;
      im_start_q  <= IM_START_RST;
      step_q      <= STEP_RST;
      iter_lim_q  <= ITER_LIM_RST;
      escape_sq_q <= ESCAPE_SQ_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RE_START:  re_start_q  <= cfg_wdata_i;
        CFG_IM_START:  im_start_q  <= cfg_wdata_i;
        CFG_STEP:      step_q      <= cfg_wdata_i[30:0];
        CFG_ITER_LIM:  iter_lim_q  <= cfg_wdata_i[7:0];
        CFG_ESCAPE_SQ: escape_sq_q <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_PX_STEP: begin
        mul_a = $signed({22'd0, px_q});
        mul_b = $signed({1'b0, step_q});
      end
      MUL_PY_STEP: begin
        mul_a = $signed({22'd0, py_q});
        mul_b = $signed({1'b0, step_q});
      end
      MUL_RE_RE: begin
        mul_a = zre_q;
        mul_b = zre_q;
      end
      MUL_IM_IM: begin
        mul_a = zim_q;
        mul_b = zim_q;
      end
      MUL_RE_IM: begin
        mul_a = zre_q;
        mul_b = zim_q;
      end
      default: begin
        mul_a = zre_q;
        mul_b = zim_q;
      end
    endcase
  end

  assign p_d = 64'(mul_a) * 64'(mul_b);

  assign cre_d   = sat32(64'(re_start_q) + p_q);
  assign cim_d   = sat32(64'(im_start_q) + p_q);
  assign zre_upd = sat32((diff_q >>> FRAC_BITS) + 64'(cre_q));
  assign zim_upd = sat32((p_q >>> (FRAC_BITS - 1)) + 64'(cim_q));

  // rr and ii are squares, so both are non-negative
  assign mag2  = {1'b0, rr_q} + {1'b0, p_q};
  assign limit = {8'd0, escape_sq_q, 26'd0};

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    if (cmd_i.load_pix) begin
      px_q <= pix_x_i;
      py_q <= pix_y_i;
    end
    if (cmd_i.set_cre) cre_q <= cre_d;
    if (cmd_i.set_cim) begin
      cim_q <= cim_d;
      zim_q <= cim_d;
      zre_q <= cre_q;
    end
    if (cmd_i.save_rr)   rr_q   <= p_q;
    if (cmd_i.save_diff) diff_q <= rr_q - p_q;
    if (cmd_i.upd_z) begin
      zre_q <= zre_upd;
      zim_q <= zim_upd;
    end
    if (cmd_i.gray_esc) gray_q <= iter_q - 8'd1;
    if (cmd_i.gray_max) gray_q <= NEVER_ESCAPED;
    if (cmd_i.out_load) begin
      out_x_q    <= px_q;
      out_y_q    <= py_q;
      out_gray_q <= gray_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
    end else if (cmd_i.load_pix) begin
      iter_q <= '0;
    end else if (cmd_i.upd_z) begin
      iter_q <= iter_q + 8'd1;
    end
  end

  assign stat_o.escaped   = mag2 > limit;
  assign stat_o.iter_done = iter_q == iter_lim_q;
  assign stat_o.iter_zero = iter_q == 8'd0;

  assign out_x_o = out_x_q;
  assign out_y_o = out_y_q;
  assign gray_o  = out_gray_q;

endmodule

// ===== rtl/core/mbet_ctrl.sv =====
// mbet_ctrl: sequencer for coordinate mapping, the iteration loop and the
// output register handshake; uses mbet_pkg, drives mbet_dp
module mbet_ctrl import mbet_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_PX_STEP;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_pix = 1'b1;
          state_d        = S_CRE;
        end
      end
      S_CRE: begin
        cmd_o.mul_sel = MUL_PX_STEP;
        state_d       = S_CIM;
      end
      S_CIM: begin
        cmd_o.set_cre = 1'b1;
        cmd_o.mul_sel = MUL_PY_STEP;
        state_d       = S_CFIN;
      end
      S_CFIN: begin
        cmd_o.set_cim = 1'b1;
        state_d       = S_RR;
      end
      S_RR: begin
        cmd_o.mul_sel = MUL_RE_RE;
        state_d       = S_II;
      end
      S_II: begin
        cmd_o.save_rr = 1'b1;
        cmd_o.mul_sel = MUL_IM_IM;
        state_d       = S_CHK;
      end
      S_CHK: begin
        if (stat_i.escaped && !stat_i.iter_zero) begin
          cmd_o.gray_esc = 1'b1;
          state_d        = S_OUT;
        end else if (stat_i.iter_done) begin
          cmd_o.gray_max = 1'b1;
          state_d        = S_OUT;
        end else begin
          cmd_o.save_diff = 1'b1;
          cmd_o.mul_sel   = MUL_RE_IM;
          state_d         = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.upd_z = 1'b1;
        state_d     = S_RR;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.out_load;
  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while still pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!in_ready_o && state_q == S_CRE))
    else $error("engine took a pixel without starting the mapping");

  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == S_OUT))
    else $error("result beat raised outside the output step");

  a_update_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.upd_z |-> !stat_i.iter_done)
    else $error("iteration past the limit");
`endif

endmodule

// ===== rtl/core/mandelbrot_escape_time.sv =====
// mandelbrot_escape_time: escape-time pixel engine, top level
// instantiates mbet_ctrl and mbet_dp; uses mbet_pkg
//
//  channel   | dir | tdata fields, low bit first         | tuser / tlast
//  s_axis    | in  | pix_x[9:0] pix_y[19:10] zero[23:20]  | none
//  m_axis    | out | out_x[9:0] out_y[19:10] gray[27:20]  | none
//  cfg       | in  | cfg_idx_i selects, cfg_wdata_i value | write on cfg_we_i
//
// each pixel runs updates up to the iteration limit; the single shared multiplier
// forms re*re, im*im and re*im in turn for each update
// rst_ni clears the sequencer and the result valid and resets the configuration
// a new pixel is taken once the previous result sits in the output register, so a stalled
// m_axis holds at most one finished beat there and one more waiting in the engine
module mandelbrot_escape_time import mbet_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // pix_x, pix_y, zero pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // out_x, out_y, gray, zero pad
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [9:0] out_x, out_y;
  logic [7:0] gray;

  mbet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mbet_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_x_i     (s_axis_tdata_i[9:0]),
    .pix_y_i     (s_axis_tdata_i[19:10]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .gray_o      (gray)
  );

  assign m_axis_tdata_o = {4'd0, gray, out_y, out_x};

endmodule
